// ===== design/mmn_pkg.sv =====
// Shared constants, codes and beat types for the min-max byte normaliser.
package mmn_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SAMPLE_W     = 32;
    localparam int PIXEL_W      = 8;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;

    localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNIT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic                       start;
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] min;
        logic signed [SAMPLE_W-1:0] max;
    } t_conv_req;

    typedef struct packed {
        logic               done;
        logic [PIXEL_W-1:0] pixel;
    } t_conv_rsp;

endpackage

// ===== design/minmax_normalize_to_byte.sv =====
// Top level of the min-max byte normaliser: control, running range and output beat.
// Load beats store a signed Q16.16 sample in a 4096-entry memory and widen the
// running minimum and maximum; drain beats return pixels in load order, with last
// set on the final stored sample, after which the block starts afresh. An accepted
// load gives no beat; a dropped load or empty drain gives a beat with only a status;
// a drain in modes 1 to 3 passes through a memory read, the conversion and the
// output hand-off; a drain in mode 0 also uses the eight-step restoring quotient
// unit unless the offset or range is not positive. One beat is in flight at a time,
// and a new one is taken while the previous result still waits in the output
// register. Write the mode only while the block is idle.
module minmax_normalize_to_byte import mmn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_beat          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_beat         o_data,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [MODE_W-1:0]          r_mode;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_drain, n_drain;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    t_out_beat                  r_res, n_res;
    logic                       r_last, n_last;
    t_out_beat                  r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic                       accept;
    logic                       slot_free;
    logic                       mem_we;
    logic signed [SAMPLE_W-1:0] rdata;
    t_conv_req                  conv_req;
    t_conv_rsp                  conv_rsp;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;
    assign mem_we    = accept && i_data.op == OP_LOAD && r_count < CNT_W'(BUFFER_DEPTH);

    mmn_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_data.sample),
        .i_raddr (r_drain[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        conv_req.start = (r_state == S_READ);
        conv_req.mode  = r_mode;
        conv_req.x     = rdata;
        conv_req.min   = r_min;
        conv_req.max   = r_max;
    end

    mmn_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .o_rsp   (conv_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drain     = r_drain;
        n_min       = r_min;
        n_max       = r_max;
        n_res       = r_res;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_data.op == OP_LOAD) begin
                        if (r_count >= CNT_W'(BUFFER_DEPTH)) begin
                            n_res   = '{pixel: '0, last: 1'b0, status: ST_FULL};
                            n_state = S_HOLD;
                        end else begin
                            if (r_count == '0) begin
                                n_min = i_data.sample;
                                n_max = i_data.sample;
                            end else begin
                                if (i_data.sample < r_min) begin
                                    n_min = i_data.sample;
                                end
                                if (i_data.sample > r_max) begin
                                    n_max = i_data.sample;
                                end
                            end
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_drain >= r_count) begin
                        n_res   = '{pixel: '0, last: 1'b0, status: ST_EMPTY};
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_last  = (r_drain + CNT_W'(1) == r_count);
                n_state = S_CALC;
                if (r_drain + CNT_W'(1) == r_count) begin
                    n_count = '0;
                    n_drain = '0;
                    n_min   = '0;
                    n_max   = '0;
                end else begin
                    n_drain = r_drain + CNT_W'(1);
                end
            end
            S_CALC: begin
                if (conv_rsp.done) begin
                    n_res   = '{pixel: conv_rsp.pixel, last: r_last, status: ST_OK};
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_STRETCH;
            r_count     <= '0;
            r_drain     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drain     <= n_drain;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_DEPTH))
        else $error("stored count beyond buffer depth");

    a_drain_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain <= r_count)
        else $error("drain index passed stored count");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_rsp.done |-> r_state == S_CALC)
        else $error("conversion finished outside the calculation state");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("running minimum above running maximum");
`endif

endmodule

// ===== design/mmn_store.sv =====
// Sample memory: one write port, one registered read port.
module mmn_store import mmn_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [BUFFER_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mmn_conv.sv =====
// Sample to pixel conversion with an iterative eight-step quotient unit.
module mmn_conv import mmn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_conv_req i_req,
    output t_conv_rsp o_rsp
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PREP = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;

    localparam int NUM_W = SAMPLE_W + PIXEL_W;

    logic [1:0]          r_phase, n_phase;
    logic                r_done, n_done;
    logic [PIXEL_W-1:0]  r_pixel, n_pixel;
    logic                r_stretch;
    logic                r_zero;
    logic [SAMPLE_W-1:0] r_off;
    logic [SAMPLE_W-1:0] r_den;
    logic [PIXEL_W-1:0]  r_fast;
    logic [NUM_W-1:0]    r_rem, n_rem;
    logic [PIXEL_W-1:0]  r_q, n_q;
    logic [2:0]          r_bit, n_bit;

    logic signed [SAMPLE_W:0]  off_full;
    logic signed [SAMPLE_W:0]  rng_full;
    logic signed [NUM_W:0]     unit_v;
    logic [PIXEL_W-1:0]        fast;
    logic [NUM_W-1:0]          num;
    logic [NUM_W-1:0]          trial;
    logic                      ge;

    always_comb begin
        off_full = (SAMPLE_W+1)'(i_req.x) - (SAMPLE_W+1)'(i_req.min);
        rng_full = (SAMPLE_W+1)'(i_req.max) - (SAMPLE_W+1)'(i_req.min);
        unit_v   = ((NUM_W+1)'(i_req.x) <<< PIXEL_W) - (NUM_W+1)'(i_req.x);
        if (i_req.mode == MODE_UNIT) begin
            if (unit_v[NUM_W] || unit_v == '0) begin
                fast = '0;
            end else if (|unit_v[NUM_W-1:16+PIXEL_W]) begin
                fast = '1;
            end else begin
                fast = unit_v[16+PIXEL_W-1:16];
            end
        end else begin
            if (i_req.x[SAMPLE_W-1] || i_req.x == '0) begin
                fast = '0;
            end else if (|i_req.x[SAMPLE_W-2:16+PIXEL_W]) begin
                fast = '1;
            end else begin
                fast = i_req.x[16+PIXEL_W-1:16];
            end
        end
    end

    always_comb begin
        num   = ({{PIXEL_W{1'b0}}, r_off} << PIXEL_W) - {{PIXEL_W{1'b0}}, r_off};
        trial = {{PIXEL_W{1'b0}}, r_den} << r_bit;
        ge    = (r_rem >= trial);
    end

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_pixel = r_pixel;
        n_rem   = r_rem;
        n_q     = r_q;
        n_bit   = r_bit;
        case (r_phase)
            C_IDLE: begin
                if (i_req.start) begin
                    n_phase = C_PREP;
                end
            end
            C_PREP: begin
                if (r_stretch && !r_zero) begin
                    n_rem   = num;
                    n_q     = '0;
                    n_bit   = 3'd7;
                    n_phase = C_DIV;
                end else begin
                    n_pixel = r_stretch ? '0 : r_fast;
                    n_done  = 1'b1;
                    n_phase = C_IDLE;
                end
            end
            C_DIV: begin
                if (ge) begin
                    n_rem = r_rem - trial;
                    n_q   = r_q | (PIXEL_W'(1) << r_bit);
                end
                if (r_bit == '0) begin
                    n_pixel = n_q;
                    n_done  = 1'b1;
                    n_phase = C_IDLE;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            default: begin
                n_phase = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_bit   <= n_bit;
        if (r_phase == C_IDLE && i_req.start) begin
            r_stretch <= (i_req.mode == MODE_STRETCH);
            r_zero    <= off_full[SAMPLE_W] || off_full == '0
                         || rng_full[SAMPLE_W] || rng_full == '0;
            r_off     <= off_full[SAMPLE_W-1:0];
            r_den     <= rng_full[SAMPLE_W-1:0];
            r_fast    <= fast;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.pixel = r_pixel;

endmodule
